@@ rtl/hand_landmarks_to_rotated_roi_core_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the hand ROI core checker
// Each macro expands to one labeled concurrent assertion on clk / arst_n.
// ---------------------------------------------------------------------------
`ifndef HAND_LANDMARKS_TO_ROTATED_ROI_CORE_DEFINES_SVH
`define HAND_LANDMARKS_TO_ROTATED_ROI_CORE_DEFINES_SVH

// same-cycle implication
`define HLRR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hlrr: same-cycle check failed");

// next-cycle implication
`define HLRR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hlrr: next-cycle check failed");

`endif

@@ rtl/hlrr_pkg.sv @@
// ---------------------------------------------------------------------------
// hlrr_pkg
// Shared constants, tables, command and status types of the hand ROI core.
// ---------------------------------------------------------------------------
package hlrr_pkg;

	localparam int NUM_LANDMARKS_DEF = 21;
	localparam int CORDIC_STEPS_DEF  = 16;
	localparam int LM_IDX_W          = 5;
	localparam int COORD_W           = 16;
	localparam int BOX_N             = 12;

	localparam int HALF_PI_Q13     = 12868;
	localparam int PI_Q13          = 25736;
	localparam int CORDIC_GAIN_Q16 = 39797;

	localparam logic [15:0]        SIDE_SCALE_RST = 16'd8192;
	localparam logic signed [12:0] SHIFT_RST      = -13'sd410;

	// config register indexes
	localparam logic CFG_SIDE_SCALE = 1'b0;
	localparam logic CFG_SHIFT      = 1'b1;

	// landmarks feeding the direction vector
	localparam logic [LM_IDX_W-1:0] LM_WRIST      = 5'd0;
	localparam logic [LM_IDX_W-1:0] LM_INDEX_MCP  = 5'd5;
	localparam logic [LM_IDX_W-1:0] LM_MIDDLE_MCP = 5'd9;
	localparam logic [LM_IDX_W-1:0] LM_RING_MCP   = 5'd13;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_V_W4,
		OP_V_W1,
		OP_V_W2,
		OP_VEC_INIT,
		OP_VEC_STEP,
		OP_ROT_INIT,
		OP_ROT_STEP,
		OP_ROT_DONE,
		OP_B1,
		OP_B1_DONE,
		OP_B2_LOAD,
		OP_B2_MA,
		OP_B2_MB,
		OP_B2_QY,
		OP_F_A,
		OP_F_B,
		OP_F_C,
		OP_F_D,
		OP_F_E,
		OP_F_F,
		OP_F_G
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic                first;
		logic [LM_IDX_W-1:0] addr;
		logic [4:0]          iter;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

	// arctangent of 2^-i, Q3.13, rounded
	function automatic logic signed [13:0] atan_q13(input logic [4:0] i);
		logic signed [13:0] v;
		case (i)
			5'd0:    v = 14'sd6434;
			5'd1:    v = 14'sd3798;
			5'd2:    v = 14'sd2007;
			5'd3:    v = 14'sd1019;
			5'd4:    v = 14'sd511;
			5'd5:    v = 14'sd256;
			5'd6:    v = 14'sd128;
			5'd7:    v = 14'sd64;
			5'd8:    v = 14'sd32;
			5'd9:    v = 14'sd16;
			5'd10:   v = 14'sd8;
			5'd11:   v = 14'sd4;
			5'd12:   v = 14'sd2;
			5'd13:   v = 14'sd1;
			default: v = 14'sd0;
		endcase
		return v;
	endfunction

	// landmarks that span the box
	function automatic logic [LM_IDX_W-1:0] box_lm(input logic [3:0] k);
		logic [LM_IDX_W-1:0] v;
		case (k)
			4'd0:    v = 5'd0;
			4'd1:    v = 5'd1;
			4'd2:    v = 5'd2;
			4'd3:    v = 5'd3;
			4'd4:    v = 5'd5;
			4'd5:    v = 5'd6;
			4'd6:    v = 5'd9;
			4'd7:    v = 5'd10;
			4'd8:    v = 5'd13;
			4'd9:    v = 5'd14;
			4'd10:   v = 5'd17;
			4'd11:   v = 5'd18;
			default: v = 5'd0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/hlrr_ctrl.sv @@
// ---------------------------------------------------------------------------
// hlrr_ctrl
// Frame sequencer: accepts landmark loads and steps the datapath per frame.
// ---------------------------------------------------------------------------
module hlrr_ctrl #(
	parameter int CORDIC_STEPS = hlrr_pkg::CORDIC_STEPS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_last,
	output logic            in_ready,
	output hlrr_pkg::cmd_t  cmd,
	input  hlrr_pkg::sts_t  sts
);

	localparam int CNT_N     = (CORDIC_STEPS > hlrr_pkg::BOX_N) ? CORDIC_STEPS : hlrr_pkg::BOX_N;
	localparam int CNT_W     = $clog2(CNT_N);
	localparam int FIN_STEPS = 6;

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b0000_0000_0001,
		ST_VLOAD  = 12'b0000_0000_0010,
		ST_VINIT  = 12'b0000_0000_0100,
		ST_VITER  = 12'b0000_0000_1000,
		ST_RINIT  = 12'b0000_0001_0000,
		ST_RITER  = 12'b0000_0010_0000,
		ST_RDONE  = 12'b0000_0100_0000,
		ST_BOX1   = 12'b0000_1000_0000,
		ST_B1DONE = 12'b0001_0000_0000,
		ST_BOX2   = 12'b0010_0000_0000,
		ST_FIN    = 12'b0100_0000_0000,
		ST_FOUT   = 12'b1000_0000_0000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]       ph_q, ph_d;

	logic cnt_box_end, cnt_iter_end;

	assign in_ready     = (state_q == ST_IDLE);
	assign cnt_box_end  = (cnt_q == CNT_W'(hlrr_pkg::BOX_N - 1));
	assign cnt_iter_end = (cnt_q == CNT_W'(CORDIC_STEPS - 1));

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		ph_d       = ph_q;
		cmd.op     = hlrr_pkg::OP_NOP;
		cmd.first  = 1'b0;
		cmd.addr   = '0;
		cmd.iter   = 5'(cnt_q);
		unique case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (in_valid && in_last) begin
					state_d = ST_VLOAD;
				end
			end
			ST_VLOAD: begin
				// wrist first (it clears the sums), then the three knuckles
				unique case (cnt_q[1:0])
					2'd0: begin
						cmd.op   = hlrr_pkg::OP_V_W4;
						cmd.addr = hlrr_pkg::LM_WRIST;
					end
					2'd1: begin
						cmd.op   = hlrr_pkg::OP_V_W1;
						cmd.addr = hlrr_pkg::LM_INDEX_MCP;
					end
					2'd2: begin
						cmd.op   = hlrr_pkg::OP_V_W2;
						cmd.addr = hlrr_pkg::LM_MIDDLE_MCP;
					end
					2'd3: begin
						cmd.op   = hlrr_pkg::OP_V_W1;
						cmd.addr = hlrr_pkg::LM_RING_MCP;
					end
					default: ;
				endcase
				cnt_d = cnt_q + 1'b1;
				if (cnt_q[1:0] == 2'd3) begin
					state_d = ST_VINIT;
				end
			end
			ST_VINIT: begin
				cmd.op  = hlrr_pkg::OP_VEC_INIT;
				cnt_d   = '0;
				state_d = ST_VITER;
			end
			ST_VITER: begin
				cmd.op = hlrr_pkg::OP_VEC_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_iter_end) begin
					state_d = ST_RINIT;
				end
			end
			ST_RINIT: begin
				cmd.op  = hlrr_pkg::OP_ROT_INIT;
				cnt_d   = '0;
				state_d = ST_RITER;
			end
			ST_RITER: begin
				cmd.op = hlrr_pkg::OP_ROT_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_iter_end) begin
					state_d = ST_RDONE;
				end
			end
			ST_RDONE: begin
				cmd.op  = hlrr_pkg::OP_ROT_DONE;
				cnt_d   = '0;
				state_d = ST_BOX1;
			end
			ST_BOX1: begin
				cmd.op    = hlrr_pkg::OP_B1;
				cmd.addr  = hlrr_pkg::box_lm(4'(cnt_q));
				cmd.first = (cnt_q == '0);
				cnt_d     = cnt_q + 1'b1;
				if (cnt_box_end) begin
					state_d = ST_B1DONE;
				end
			end
			ST_B1DONE: begin
				cmd.op  = hlrr_pkg::OP_B1_DONE;
				cnt_d   = '0;
				ph_d    = '0;
				state_d = ST_BOX2;
			end
			ST_BOX2: begin
				cmd.addr  = hlrr_pkg::box_lm(4'(cnt_q));
				cmd.first = (cnt_q == '0);
				unique case (ph_q)
					2'd0: cmd.op = hlrr_pkg::OP_B2_LOAD;
					2'd1: cmd.op = hlrr_pkg::OP_B2_MA;
					2'd2: cmd.op = hlrr_pkg::OP_B2_MB;
					2'd3: cmd.op = hlrr_pkg::OP_B2_QY;
					default: ;
				endcase
				ph_d = ph_q + 1'b1;
				if (ph_q == 2'd3) begin
					cnt_d = cnt_q + 1'b1;
					if (cnt_box_end) begin
						cnt_d   = '0;
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				unique case (cnt_q[2:0])
					3'd0:    cmd.op = hlrr_pkg::OP_F_A;
					3'd1:    cmd.op = hlrr_pkg::OP_F_B;
					3'd2:    cmd.op = hlrr_pkg::OP_F_C;
					3'd3:    cmd.op = hlrr_pkg::OP_F_D;
					3'd4:    cmd.op = hlrr_pkg::OP_F_E;
					3'd5:    cmd.op = hlrr_pkg::OP_F_F;
					default: cmd.op = hlrr_pkg::OP_NOP;
				endcase
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(FIN_STEPS - 1)) begin
					state_d = ST_FOUT;
				end
			end
			ST_FOUT: begin
				// final write waits until the output register is free;
				// the shift products are kept live meanwhile
				if (sts.out_free) begin
					cmd.op  = hlrr_pkg::OP_F_G;
					state_d = ST_IDLE;
				end else begin
					cmd.op = hlrr_pkg::OP_F_F;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ph_q    <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ph_q    <= ph_d;
		end
	end

endmodule

@@ rtl/hlrr_datapath.sv @@
// ---------------------------------------------------------------------------
// hlrr_datapath
// Landmark store, shared CORDIC, box trackers, multipliers, output register.
// ---------------------------------------------------------------------------
module hlrr_datapath #(
	parameter int NUM_LANDMARKS = hlrr_pkg::NUM_LANDMARKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [hlrr_pkg::LM_IDX_W-1:0] wr_idx,
	input  logic signed [15:0]            wr_x,
	input  logic signed [15:0]            wr_y,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [15:0]                   cfg_data,
	input  hlrr_pkg::cmd_t                cmd,
	output hlrr_pkg::sts_t                sts,
	output logic signed [17:0]            center_x,
	output logic signed [17:0]            center_y,
	output logic [18:0]                   side,
	output logic signed [15:0]            rotation,
	output logic                          out_valid,
	input  logic                          out_ready
);

	localparam int ADDR_W = $clog2(NUM_LANDMARKS);
	localparam int CW     = 23;  // CORDIC x/y
	localparam int QW     = 36;  // rotated projections, Q.29
	localparam int AW     = 60;  // centre accumulators, Q.46

	logic signed [15:0] mem_x [NUM_LANDMARKS];
	logic signed [15:0] mem_y [NUM_LANDMARKS];
	logic signed [15:0] rd_x_q, rd_y_q;
	hlrr_pkg::cmd_t     cmd_s1;

	logic [15:0]        scale_q;
	logic signed [12:0] shift_q;

	logic signed [19:0] ax_q, ay_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [16:0] cz_q;
	logic               zero_q, flip_q;
	logic signed [15:0] rot_q;
	logic signed [18:0] c_q, s_q;
	logic [18:0]        side_q;

	logic signed [15:0] l_q, r_q, t_q, b_q;
	logic signed [16:0] sx_q, sy_q;
	logic signed [17:0] px_q, py_q;
	logic signed [QW-1:0] pl_q, pr_q, pt_q, pb_q;
	logic signed [QW:0]   pcx2_q, pcy2_q, h_q, mx_q;
	logic signed [AW-1:0] cxacc_q, cyacc_q;
	logic signed [38:0]   hs_q;

	logic signed [38:0] mul_a0, mul_a1;
	logic signed [18:0] mul_b0, mul_b1;
	logic signed [57:0] m0_q, m1_q;

	logic signed [CW-1:0] dx, dy, vx0, vy0;
	logic signed [16:0]   at, zsat, zfold;
	logic                 zfl;
	logic signed [15:0]   rotv;
	logic signed [57:0]   qsum, qdif;
	logic signed [QW-1:0] qx, qy;
	logic signed [QW:0]   wv, hv;
	logic signed [57:0]   sd_sh;
	logic [18:0]          side_v;
	logic signed [AW-1:0] cxf, cyf, cxr, cyr;
	logic signed [17:0]   cx_v, cy_v;

	// landmark store, registered read
	always_ff @(posedge clk) begin
		if (wr_en && (32'(wr_idx) < NUM_LANDMARKS)) begin
			mem_x[wr_idx[ADDR_W-1:0]] <= wr_x;
			mem_y[wr_idx[ADDR_W-1:0]] <= wr_y;
		end
		rd_x_q <= mem_x[cmd.addr[ADDR_W-1:0]];
		rd_y_q <= mem_y[cmd.addr[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1    <= '{op: hlrr_pkg::OP_NOP, first: 1'b0, addr: '0, iter: '0};
			scale_q   <= hlrr_pkg::SIDE_SCALE_RST;
			shift_q   <= hlrr_pkg::SHIFT_RST;
			out_valid <= 1'b0;
		end else begin
			cmd_s1 <= cmd;
			if (cfg_we) begin
				unique case (cfg_index)
					hlrr_pkg::CFG_SIDE_SCALE: scale_q <= cfg_data;
					hlrr_pkg::CFG_SHIFT:      shift_q <= cfg_data[12:0];
					default: ;
				endcase
			end
			if (cmd_s1.op == hlrr_pkg::OP_F_G) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign sts.out_free = !out_valid || out_ready;

	// multiplier operand select
	always_comb begin
		mul_a0 = '0;
		mul_b0 = '0;
		mul_a1 = '0;
		mul_b1 = '0;
		unique case (cmd_s1.op)
			hlrr_pkg::OP_B2_MA: begin
				mul_a0 = 39'(px_q);
				mul_b0 = c_q;
				mul_a1 = 39'(py_q);
				mul_b1 = s_q;
			end
			hlrr_pkg::OP_B2_MB: begin
				mul_a0 = 39'(py_q);
				mul_b0 = c_q;
				mul_a1 = 39'(px_q);
				mul_b1 = s_q;
			end
			hlrr_pkg::OP_F_B: begin
				mul_a0 = 39'(pcx2_q);
				mul_b0 = c_q;
				mul_a1 = 39'(pcy2_q);
				mul_b1 = s_q;
			end
			hlrr_pkg::OP_F_C: begin
				mul_a0 = 39'(pcx2_q);
				mul_b0 = s_q;
				mul_a1 = 39'(pcy2_q);
				mul_b1 = c_q;
			end
			hlrr_pkg::OP_F_D: begin
				mul_a0 = 39'(h_q);
				mul_b0 = 19'(shift_q);
				mul_a1 = 39'(mx_q);
				mul_b1 = $signed({3'b000, scale_q});
			end
			hlrr_pkg::OP_F_F: begin
				mul_a0 = hs_q;
				mul_b0 = s_q;
				mul_a1 = hs_q;
				mul_b1 = c_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		m0_q <= 58'(mul_a0) * 58'(mul_b0);
		m1_q <= 58'(mul_a1) * 58'(mul_b1);
	end

	always_comb begin
		dx  = cy_q >>> cmd_s1.iter;
		dy  = cx_q >>> cmd_s1.iter;
		at  = 17'(hlrr_pkg::atan_q13(cmd_s1.iter));
		vx0 = CW'(ay_q);
		vy0 = CW'(ax_q);

		if (cz_q > 17'(hlrr_pkg::PI_Q13)) begin
			zsat = 17'(hlrr_pkg::PI_Q13);
		end else if (cz_q < -17'(hlrr_pkg::PI_Q13)) begin
			zsat = -17'(hlrr_pkg::PI_Q13);
		end else begin
			zsat = cz_q;
		end
		rotv = zero_q ? 16'sd0 : 16'(zsat);

		// fold into the right half plane before sin/cos
		if (17'(rotv) > 17'(hlrr_pkg::HALF_PI_Q13)) begin
			zfold = 17'(rotv) - 17'(hlrr_pkg::PI_Q13);
			zfl   = 1'b1;
		end else if (17'(rotv) < -17'(hlrr_pkg::HALF_PI_Q13)) begin
			zfold = 17'(rotv) + 17'(hlrr_pkg::PI_Q13);
			zfl   = 1'b1;
		end else begin
			zfold = 17'(rotv);
			zfl   = 1'b0;
		end

		qsum = m0_q + m1_q;
		qdif = m0_q - m1_q;
		qx   = QW'(qsum);
		qy   = QW'(qdif);
		wv   = 37'(pr_q) - 37'(pl_q);
		hv   = 37'(pb_q) - 37'(pt_q);

		sd_sh  = (m1_q + 58'sd268435456) >>> 29;
		side_v = (sd_sh > 58'sd524287) ? 19'h7FFFF : 19'(sd_sh);

		cxf = cxacc_q - AW'(m0_q);
		cyf = cyacc_q + AW'(m1_q);
		cxr = (cxf + (AW'(1) <<< 33)) >>> 34;
		cyr = (cyf + (AW'(1) <<< 33)) >>> 34;
		if (cxr > AW'(131071)) begin
			cx_v = 18'sd131071;
		end else if (cxr < -AW'(131072)) begin
			cx_v = -18'sd131072;
		end else begin
			cx_v = 18'(cxr);
		end
		if (cyr > AW'(131071)) begin
			cy_v = 18'sd131071;
		end else if (cyr < -AW'(131072)) begin
			cy_v = -18'sd131072;
		end else begin
			cy_v = 18'(cyr);
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd_s1.op)
			hlrr_pkg::OP_V_W4: begin
				ax_q <= -(20'(rd_x_q) <<< 2);
				ay_q <= 20'(rd_y_q) <<< 2;
			end
			hlrr_pkg::OP_V_W1: begin
				ax_q <= ax_q + 20'(rd_x_q);
				ay_q <= ay_q - 20'(rd_y_q);
			end
			hlrr_pkg::OP_V_W2: begin
				ax_q <= ax_q + (20'(rd_x_q) <<< 1);
				ay_q <= ay_q - (20'(rd_y_q) <<< 1);
			end
			hlrr_pkg::OP_VEC_INIT: begin
				zero_q <= (ax_q == '0) && (ay_q == '0);
				if (vx0 < 0) begin
					if (vy0 >= 0) begin
						cx_q <= vy0;
						cy_q <= -vx0;
						cz_q <= 17'(hlrr_pkg::HALF_PI_Q13);
					end else begin
						cx_q <= -vy0;
						cy_q <= vx0;
						cz_q <= -17'(hlrr_pkg::HALF_PI_Q13);
					end
				end else begin
					cx_q <= vx0;
					cy_q <= vy0;
					cz_q <= '0;
				end
			end
			hlrr_pkg::OP_VEC_STEP: begin
				if (cy_q > 0) begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					cz_q <= cz_q + at;
				end else begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					cz_q <= cz_q - at;
				end
			end
			hlrr_pkg::OP_ROT_INIT: begin
				rot_q  <= rotv;
				cx_q   <= CW'(hlrr_pkg::CORDIC_GAIN_Q16);
				cy_q   <= '0;
				cz_q   <= zfold;
				flip_q <= zfl;
			end
			hlrr_pkg::OP_ROT_STEP: begin
				if (cz_q >= 0) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					cz_q <= cz_q + at;
				end
			end
			hlrr_pkg::OP_ROT_DONE: begin
				c_q <= flip_q ? 19'(-cx_q) : 19'(cx_q);
				s_q <= flip_q ? 19'(-cy_q) : 19'(cy_q);
			end
			hlrr_pkg::OP_B1: begin
				if (cmd_s1.first) begin
					l_q <= rd_x_q;
					r_q <= rd_x_q;
					t_q <= rd_y_q;
					b_q <= rd_y_q;
				end else begin
					if (rd_x_q < l_q) l_q <= rd_x_q;
					if (rd_x_q > r_q) r_q <= rd_x_q;
					if (rd_y_q < t_q) t_q <= rd_y_q;
					if (rd_y_q > b_q) b_q <= rd_y_q;
				end
			end
			hlrr_pkg::OP_B1_DONE: begin
				sx_q <= 17'(l_q) + 17'(r_q);
				sy_q <= 17'(t_q) + 17'(b_q);
			end
			hlrr_pkg::OP_B2_LOAD: begin
				px_q <= (18'(rd_x_q) <<< 1) - 18'(sx_q);
				py_q <= (18'(rd_y_q) <<< 1) - 18'(sy_q);
			end
			hlrr_pkg::OP_B2_MB: begin
				if (cmd_s1.first || qx < pl_q) pl_q <= qx;
				if (cmd_s1.first || qx > pr_q) pr_q <= qx;
			end
			hlrr_pkg::OP_B2_QY: begin
				if (cmd_s1.first || qy < pt_q) pt_q <= qy;
				if (cmd_s1.first || qy > pb_q) pb_q <= qy;
			end
			hlrr_pkg::OP_F_A: begin
				pcx2_q <= 37'(pl_q) + 37'(pr_q);
				pcy2_q <= 37'(pt_q) + 37'(pb_q);
				h_q    <= hv;
				mx_q   <= (wv > hv) ? wv : hv;
			end
			hlrr_pkg::OP_F_C: begin
				cxacc_q <= AW'(m0_q) - AW'(m1_q) + (AW'(sx_q) <<< 33);
			end
			hlrr_pkg::OP_F_D: begin
				cyacc_q <= AW'(m0_q) + AW'(m1_q) + (AW'(sy_q) <<< 33);
			end
			hlrr_pkg::OP_F_E: begin
				hs_q   <= 39'(m0_q >>> 11);
				side_q <= side_v;
			end
			hlrr_pkg::OP_F_G: begin
				center_x <= cx_v;
				center_y <= cy_v;
				side     <= side_q;
				rotation <= rot_q;
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/hand_landmarks_to_rotated_roi_core.sv @@
// ---------------------------------------------------------------------------
// hand_landmarks_to_rotated_roi_core
// Hand landmarks in, rotated square region (centre, side, rotation) out.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel: one landmark per transfer (index, x, y in Q4.12). A
//   transfer with s_tlast set starts the frame computation; s_tready stays
//   low until it is done.
//   m_* channel: one result per frame (centre Q6.12, side Q7.12, rotation
//   Q3.13 radians), held stable while m_tready is low.
//   cfg port: side_scale (index 0) and shift_along_hand (index 1), written
//   while the core is idle.
// Sequence:
//   after the last transfer the core works through the wrist and three
//   knuckle reads, the vectoring and rotation CORDIC passes of one step per
//   cycle, 12 box reads, the rotated box through the shared multiplier pair
//   and 6 finishing steps, then the final write of the result.
// Reset: clears the sequencer, the output valid and the config registers to
//   their defaults; the landmark store is left unwritten.
// Stall: while a result waits, new landmarks are still taken; a next frame
//   holds before its final step until the waiting result is taken.
// ---------------------------------------------------------------------------
module hand_landmarks_to_rotated_roi_core #(
	parameter int NUM_LANDMARKS = hlrr_pkg::NUM_LANDMARKS_DEF,
	parameter int CORDIC_STEPS  = hlrr_pkg::CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// landmark input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // landmark_index[4:0], landmark_x[20:5], landmark_y[36:21]
	input  logic        s_tlast,   // last
	// region output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // center_x[17:0], center_y[35:18], side[54:36], rotation[70:55]
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	hlrr_pkg::cmd_t cmd;
	hlrr_pkg::sts_t sts;

	logic               s_xfer;
	logic signed [17:0] center_x, center_y;
	logic [18:0]        side;
	logic signed [15:0] rotation;

	assign s_xfer = s_tvalid && s_tready;

	hlrr_ctrl #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	hlrr_datapath #(
		.NUM_LANDMARKS (NUM_LANDMARKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (s_xfer),
		.wr_idx    (s_tdata[4:0]),
		.wr_x      ($signed(s_tdata[20:5])),
		.wr_y      ($signed(s_tdata[36:21])),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.center_x  (center_x),
		.center_y  (center_y),
		.side      (side),
		.rotation  (rotation),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);

	assign m_tdata = {1'b0, rotation, side, center_y, center_x};

endmodule

@@ rtl/hlrr_checker.sv @@
// ---------------------------------------------------------------------------
// hlrr_checker
// Port-level checks of the hand ROI core, bound to the top level.
// ---------------------------------------------------------------------------
`include "hand_landmarks_to_rotated_roi_core_defines.svh"

module hlrr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	// stalled result holds
	`HLRR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// rotation stays within plus or minus pi
	`HLRR_ASSERT_IMPL(a_rot_range, m_tvalid, ($signed(m_tdata[70:55]) <= 16'sd25736) && ($signed(m_tdata[70:55]) >= -16'sd25736))
	// a frame end blocks further input
	`HLRR_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready)
	// a fresh result comes only out of a busy period
	`HLRR_ASSERT_IMPL(a_result_from_frame, $rose(m_tvalid), !$past(s_tready, 2))

endmodule

bind hand_landmarks_to_rotated_roi_core hlrr_checker u_chk (.*);
